// File: design/assert_macros.svh
// assertion macros shared by the moving average design files
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: design/mas_pkg.sv
// shared types and constants of the moving average filter
// no dependencies
`timescale 1ns / 1ps

package mas_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int CNT_BITS    = 7;
    localparam int CFG_BITS    = 7;
    localparam int IDX_BITS    = 1;
    // history is a few slots deeper than the window so queued words never overwrite
    // the samples still being read for an older word
    localparam int HIST_DEPTH  = MAX_WINDOW + 4;
    localparam int SLOT_BITS   = $clog2(HIST_DEPTH);
    localparam int TOT_BITS    = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + TOT_BITS + 1;
    localparam int PSUM_BITS   = SAMPLE_BITS + CNT_BITS;
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [IDX_BITS-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_WEIGHTED_MODE = 1'b1;

    localparam logic [CNT_BITS-1:0] WINDOW_RESET = 7'd8;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          restart;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [CNT_BITS-1:0]           samples_used;
    } result_t;

    typedef struct packed {
        logic                          en;
        logic [SLOT_BITS-1:0]          addr;
        logic signed [SAMPLE_BITS-1:0] data;
    } hist_wr_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] newest;
        logic [CNT_BITS-1:0]  count;
        logic                 weighted;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: design/mas_front.sv
// front end: accepts sample words, holds configuration, writes history
// and queues one averaging job per word; depends on mas_pkg
`timescale 1ns / 1ps

module mas_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  mas_pkg::item_t              item,
    input  logic                        cfg_write,
    input  logic [mas_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [mas_pkg::CFG_BITS-1:0] cfg_data,
    input  mas_pkg::queue_stat_t        q_stat,
    output logic                        job_push,
    output mas_pkg::job_t               job,
    output mas_pkg::hist_wr_t           hist_wr
);
    import mas_pkg::*;

    logic [CNT_BITS-1:0]  wlen_reg;
    logic                 weighted_reg;
    logic [SLOT_BITS-1:0] wptr_reg, wptr_next;
    logic [CNT_BITS-1:0]  fill_reg, fill_next;
    logic [CNT_BITS-1:0]  fill_base;
    logic [CNT_BITS-1:0]  win_eff;
    logic                 accept;

    assign item_stall = q_stat.full;
    assign accept     = item_valid && !q_stat.full;

    // effective window: zero acts as one, oversize saturates
    always_comb
    begin
        if (wlen_reg == '0)
            win_eff = CNT_BITS'(1);
        else if (wlen_reg > CNT_BITS'(MAX_WINDOW))
            win_eff = CNT_BITS'(MAX_WINDOW);
        else
            win_eff = wlen_reg;
    end

    // fill count after this word, restart drops the history first
    always_comb
    begin
        fill_base = item.restart ? '0 : fill_reg;
        if (fill_base < CNT_BITS'(MAX_WINDOW))
            fill_next = fill_base + CNT_BITS'(1);
        else
            fill_next = fill_base;
        if (wptr_reg == SLOT_BITS'(HIST_DEPTH - 1))
            wptr_next = '0;
        else
            wptr_next = wptr_reg + SLOT_BITS'(1);
    end

    // history write and job for the back end
    always_comb
    begin
        hist_wr.en      = accept;
        hist_wr.addr    = wptr_reg;
        hist_wr.data    = item.sample;
        job_push        = accept;
        job.newest      = wptr_reg;
        job.count       = (fill_next < win_eff) ? fill_next : win_eff;
        job.weighted    = weighted_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg     <= WINDOW_RESET;
            weighted_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH: wlen_reg     <= cfg_data;
                REG_WEIGHTED_MODE: weighted_reg <= cfg_data[0];
                default:           wlen_reg     <= wlen_reg;
            endcase
        end
    end

    // write pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            wptr_reg <= wptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// File: design/mas_queue.sv
// short job queue between front and back end
// depends on mas_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mas_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mas_pkg::job_t        push_job,
    input  logic                 pop,
    output mas_pkg::job_t        head,
    output mas_pkg::queue_stat_t stat
);
    import mas_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    job_t                q_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;

    assign head       = q_mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_job;
    end

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_BITS'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    `ASSERT_AT(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_AT(a_ptr_match, clk, rst_n, (stat.empty || stat.full) |-> (wr_ptr_reg == rd_ptr_reg))
    `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && stat.full && !pop)
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && stat.empty)

endmodule

// File: design/mas_back.sv
// back end: history memory, serial sum over the window, restoring divider
// and result register; depends on mas_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mas_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mas_pkg::hist_wr_t    hist_wr,
    input  mas_pkg::queue_stat_t q_stat,
    input  mas_pkg::job_t        job,
    output logic                 job_pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output mas_pkg::result_t     result
);
    import mas_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    localparam int STEP_BITS = $clog2(SUM_BITS);

    logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];

    logic [1:0]                    state_reg, state_next;
    logic [SLOT_BITS-1:0]          slot_reg, slot_next;
    logic [CNT_BITS-1:0]           n_reg, n_next;
    logic                          mode_reg, mode_next;
    logic [CNT_BITS-1:0]           k_reg, k_next;
    logic                          pend_reg, pend_next;
    logic [CNT_BITS-1:0]           weight_reg, weight_next;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [PSUM_BITS-1:0]   psum_reg, psum_next;
    logic signed [SUM_BITS-1:0]    wsum_reg, wsum_next;
    logic [TOT_BITS-1:0]           dvsr_reg, dvsr_next;
    logic [SUM_BITS-1:0]           quo_reg, quo_next;
    logic [TOT_BITS-1:0]           rem_reg, rem_next;
    logic                          neg_reg, neg_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic                          result_valid_reg, result_valid_next;
    result_t                       result_reg, result_next;

    logic signed [PSUM_BITS:0]     prod;
    logic [CNT_BITS:0]             cnt_p1;
    logic [2*CNT_BITS:0]           tri_prod;
    logic signed [SUM_BITS-1:0]    dvd;
    logic [SUM_BITS-1:0]           dvd_mag;
    logic [TOT_BITS:0]             rem_sh;
    logic                          rem_ge;
    logic [SUM_BITS-1:0]           quo_fix;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // history store: one write port from the front, one registered read port
    always_ff @(posedge clk)
    begin
        if (hist_wr.en)
            hist_mem[hist_wr.addr] <= hist_wr.data;
        rd_data_reg <= hist_mem[slot_reg];
    end

    // datapath pieces
    always_comb
    begin
        prod     = (PSUM_BITS + 1)'(rd_data_reg) * (PSUM_BITS + 1)'($signed({1'b0, weight_reg}));
        cnt_p1   = {1'b0, job.count} + (CNT_BITS + 1)'(1);
        tri_prod = (2 * CNT_BITS + 1)'(job.count) * (2 * CNT_BITS + 1)'(cnt_p1);
        dvd      = mode_reg ? wsum_reg : SUM_BITS'(psum_reg);
        dvd_mag  = dvd[SUM_BITS-1] ? SUM_BITS'(-dvd) : SUM_BITS'(dvd);
        rem_sh   = {rem_reg, quo_reg[SUM_BITS-1]};
        rem_ge   = (rem_sh >= {1'b0, dvsr_reg});
        quo_fix  = neg_reg ? (~quo_reg + SUM_BITS'(1)) : quo_reg;
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        slot_next         = slot_reg;
        n_next            = n_reg;
        mode_next         = mode_reg;
        k_next            = k_reg;
        pend_next         = 1'b0;
        weight_next       = weight_reg;
        psum_next         = psum_reg;
        wsum_next         = wsum_reg;
        dvsr_next         = dvsr_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        neg_next          = neg_reg;
        step_next         = step_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        job_pop           = 1'b0;

        // accumulate the word read in the previous cycle
        if (pend_reg)
        begin
            psum_next = psum_reg + PSUM_BITS'(rd_data_reg);
            wsum_next = wsum_reg + SUM_BITS'(prod);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    job_pop    = 1'b1;
                    slot_next  = job.newest;
                    n_next     = job.count;
                    mode_next  = job.weighted;
                    k_next     = '0;
                    psum_next  = '0;
                    wsum_next  = '0;
                    dvsr_next  = job.weighted ? TOT_BITS'(tri_prod >> 1)
                                              : TOT_BITS'(job.count);
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (k_reg != n_reg)
                begin
                    // read newest first, weight falls by one per older sample
                    pend_next   = 1'b1;
                    weight_next = n_reg - k_reg;
                    k_next      = k_reg + CNT_BITS'(1);
                    slot_next   = (slot_reg == '0) ? SLOT_BITS'(HIST_DEPTH - 1)
                                                   : slot_reg - SLOT_BITS'(1);
                end
                else if (!pend_reg)
                begin
                    quo_next   = dvd_mag;
                    rem_next   = '0;
                    neg_next   = dvd[SUM_BITS-1];
                    step_next  = STEP_BITS'(SUM_BITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                rem_next = rem_ge ? TOT_BITS'(rem_sh - {1'b0, dvsr_reg}) : TOT_BITS'(rem_sh);
                quo_next = {quo_reg[SUM_BITS-2:0], rem_ge};
                if (step_reg == '0)
                    state_next = ST_HOLD;
                else
                    step_next = step_reg - STEP_BITS'(1);
            end
            ST_HOLD:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next        = 1'b1;
                    result_next.average      = quo_fix[SAMPLE_BITS-1:0];
                    result_next.samples_used = n_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        n_reg      <= n_next;
        mode_reg   <= mode_next;
        k_reg      <= k_next;
        weight_reg <= weight_next;
        psum_reg   <= psum_next;
        wsum_reg   <= wsum_next;
        dvsr_reg   <= dvsr_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        step_reg   <= step_next;
        result_reg <= result_next;
    end

    `ASSERT_AT(a_k_bound, clk, rst_n, (state_reg == ST_ACC) |-> (k_reg <= n_reg))
    `ASSERT_AT(a_dvsr_nonzero, clk, rst_n, (state_reg == ST_DIV) |-> (dvsr_reg != '0))
    `ASSERT_AT(a_n_bound, clk, rst_n, (state_reg != ST_IDLE) |-> (|n_reg && n_reg <= CNT_BITS'(MAX_WINDOW)))
    `ASSERT_AT(a_hold_wait, clk, rst_n, (state_reg == ST_HOLD && result_valid_reg && result_stall) |=> (state_reg == ST_HOLD))

endmodule

// File: design/moving_average_sma_wma.sv
// each word's average comes from a serial window sum and the one-bit-per-cycle divider;
// the back end finishes one word before it takes the next, and the job queue takes up to
// two words ahead
// on reset, control, pointers, fill count and configuration registers reset at once; datapath
// registers and history memory are not cleared, and history needs no clearing pass
`timescale 1ns / 1ps

module moving_average_sma_wma (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  mas_pkg::item_t               item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output mas_pkg::result_t             result,
    input  logic                         cfg_write,
    input  logic [mas_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [mas_pkg::CFG_BITS-1:0] cfg_data
);
    import mas_pkg::*;

    hist_wr_t    hist_wr;
    queue_stat_t q_stat;
    job_t        push_job;
    job_t        head_job;
    logic        job_push;
    logic        job_pop;

    // accept words, hold configuration, write history and queue jobs
    mas_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .job_push   (job_push),
        .job        (push_job),
        .hist_wr    (hist_wr)
    );

    // job queue
    mas_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head     (head_job),
        .stat     (q_stat)
    );

    // sum, divide and deliver
    mas_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .hist_wr      (hist_wr),
        .q_stat       (q_stat),
        .job          (head_job),
        .job_pop      (job_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: dv/moving_average_sma_wma_test.sv
// self-checking testbench for the moving average filter, simple and weighted modes
// depends on mas_pkg and moving_average_sma_wma; random idling on both channels
`timescale 1ns / 1ps

module moving_average_sma_wma_test;

    import mas_pkg::*;

    localparam int STUCK_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 150;
    localparam int RAND_PHASES   = 13;
    localparam int PHASE_WORDS   = 40;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    item_t               item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    result_t             result;
    logic                cfg_write    = 1'b0;
    logic [IDX_BITS-1:0] cfg_index    = REG_WINDOW_LENGTH;
    logic [CFG_BITS-1:0] cfg_data     = '0;

    // words waiting to be sent and averages waiting to come back
    item_t   sample_queue[$];
    result_t averages_due[$];

    // filter state as the testbench sees it
    logic signed [SAMPLE_BITS-1:0] hist_copy [MAX_WINDOW];
    int                            next_slot    = 0;
    int                            held         = 0;
    logic [CFG_BITS-1:0]           window_reg   = WINDOW_RESET;
    logic                          weighted_reg = 1'b0;

    int errors      = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int stuck_count = 0;
    bit quiet_phase = 1'b0;
    int ph;
    int i;

    moving_average_sma_wma uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic note_fault(input string what);
        errors++;
        $display("%0t: %s", $time, what);
    endtask

    // take one sample into the history and work out the average it produces
    function automatic result_t advance_filter(input item_t word);
        result_t expd;
        int      eff;
        int      used;
        int      k;
        int      slot;
        longint  plain;
        longint  weighted;
        longint  avg;
        if (word.restart)
        begin
            held      = 0;
            next_slot = 0;
        end
        hist_copy[next_slot] = word.sample;
        next_slot = (next_slot + 1) % MAX_WINDOW;
        if (held < MAX_WINDOW)
            held++;
        eff  = (window_reg == 0) ? 1 : ((window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg);
        used = (held < eff) ? held : eff;
        // walk back from the newest sample, weight falls by one per step
        slot     = next_slot;
        plain    = 0;
        weighted = 0;
        for (k = 0; k < used; k++)
        begin
            slot      = (slot == 0) ? MAX_WINDOW - 1 : slot - 1;
            plain    += longint'(hist_copy[slot]);
            weighted += longint'(hist_copy[slot]) * longint'(used - k);
        end
        if (weighted_reg)
            avg = weighted / longint'(used * (used + 1) / 2);
        else
            avg = plain / longint'(used);
        expd.average      = avg[SAMPLE_BITS-1:0];
        expd.samples_used = used[CNT_BITS-1:0];
        return expd;
    endfunction

    // mostly no pause, some short ones, a few long ones, none in a quiet phase
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7fff;
            1:       v = 16'h8000;
            2, 3:    v = 16'($urandom_range(0, 63)) - 16'd32;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] s, input logic rs);
        item_t word;
        word.sample  = s;
        word.restart = rs;
        sample_queue.push_back(word);
    endtask

    // register write, only issued with nothing in flight
    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_WINDOW_LENGTH)
            window_reg = val;
        else
            weighted_reg = val[0];
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || item_valid || averages_due.size() != 0);
    endtask

    // driver: present queued words, hold while stalled, pause at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                averages_due.push_back(advance_filter(item));
                gap_left = pick_pause();
            end
            if (!(item_valid && item_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    item       <= sample_queue.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted result with the oldest expected average
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (averages_due.size() == 0)
                    note_fault($sformatf("unexpected result avg %0d used %0d",
                                         result.average, result.samples_used));
                else
                begin
                    if (result.average !== averages_due[0].average)
                        note_fault($sformatf("average %0d, wanted %0d",
                                             result.average, averages_due[0].average));
                    if (result.samples_used !== averages_due[0].samples_used)
                        note_fault($sformatf("samples_used %0d, wanted %0d",
                                             result.samples_used,
                                             averages_due[0].samples_used));
                    void'(averages_due.pop_front());
                end
            end
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_pause();
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write)
                stuck_count <= 0;
            else if (stuck_count >= STUCK_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                stuck_count <= stuck_count + 1;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset window of 8, simple mean: extremes through warm-up
        queue_sample(16'h7fff, 1'b0);
        queue_sample(16'h7fff, 1'b0);
        queue_sample(16'h7fff, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'hffff, 1'b0);
        queue_sample(16'h0001, 1'b0);
        // restart, then negative quotients that truncate toward zero
        queue_sample(-16'sd5, 1'b1);
        queue_sample(16'sd3, 1'b0);
        queue_sample(-16'sd2, 1'b0);
        wait_drained();

        // weighted mean over a short window
        write_reg(REG_WEIGHTED_MODE, 7'd1);
        write_reg(REG_WINDOW_LENGTH, 7'd4);
        queue_sample(16'h7fff, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h7fff, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(-16'sd3, 1'b0);
        queue_sample(16'sd7, 1'b0);
        wait_drained();

        // zero window behaves as one
        write_reg(REG_WINDOW_LENGTH, 7'd0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h1234, 1'b0);
        wait_drained();

        // oversized window saturates, new window applies to held history at once
        write_reg(REG_WINDOW_LENGTH, 7'd127);
        write_reg(REG_WEIGHTED_MODE, 7'd0);
        queue_sample(16'h7fff, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'h8000, 1'b0);
        wait_drained();

        // random phases: extreme windows in both modes first, then random windows, mode alternating by phase
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0, 1:    write_reg(REG_WINDOW_LENGTH, 7'd1);
                2, 3:    write_reg(REG_WINDOW_LENGTH, 7'd64);
                4:       write_reg(REG_WINDOW_LENGTH, 7'd127);
                5:       write_reg(REG_WINDOW_LENGTH, 7'd0);
                6:       write_reg(REG_WINDOW_LENGTH, 7'd65);
                7:       write_reg(REG_WINDOW_LENGTH, 7'd2);
                default: write_reg(REG_WINDOW_LENGTH, 7'($urandom_range(0, 127)));
            endcase
            // upper data bits are junk for the mode register
            write_reg(REG_WEIGHTED_MODE, {6'($urandom()), ph[0]});
            quiet_phase = (ph % 4 == 3);
            for (i = 0; i < PHASE_WORDS; i++)
                queue_sample(pick_sample(), $urandom_range(0, 39) == 0);
            wait_drained();
        end

        quiet_phase = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (averages_due.size() != 0)
        begin
            note_fault($sformatf("no result for expected average %0d",
                                 averages_due[0].average));
            void'(averages_due.pop_front());
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
